/* rtl/core/vmt_pkg.sv */
// Package for vector_move_towards: widths, defaults and lane/pipeline types.
// Used by every module in rtl/core; no dependencies.
package vmt_pkg;

    localparam int COORD_W     = 32;
    localparam int DIFF_W      = 33;
    localparam int MAG_W       = 32;
    localparam int SQ_W        = 64;
    localparam int SUM_W       = 66;
    localparam int STEP_W      = 31;
    localparam int ROOT_W      = 34;
    localparam int PROD_W      = MAG_W + STEP_W;
    localparam int EPSILON_DEF = 1;
    localparam int LANES       = 3;

    typedef struct packed {
        logic                      neg;
        logic [MAG_W-1:0]          mag;
        logic signed [COORD_W-1:0] cur;
        logic signed [COORD_W-1:0] tgt;
    } lane_t;

endpackage

/* rtl/core/vmt_sqrt_stage.sv */
// One restoring step of the floor square root, plus the pass-through payload.
// Depends on vmt_pkg.
module vmt_sqrt_stage #(
    parameter int BIT = 0,
    parameter int PW  = 1
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [vmt_pkg::SUM_W-1:0]  rem_in,
    input  logic [vmt_pkg::ROOT_W-1:0] root_in,
    input  logic [PW-1:0]              pay_in,
    output logic [vmt_pkg::SUM_W-1:0]  rem_out,
    output logic [vmt_pkg::ROOT_W-1:0] root_out,
    output logic [PW-1:0]              pay_out
);
    // bit-by-bit method: trial = (root<<(BIT+1)) + (1<<2*BIT), on a 68-bit scale
    localparam int TW = vmt_pkg::SUM_W + 2;

    logic [TW-1:0] trial;
    logic [TW-1:0] rem_w;
    logic          fits;

    always_comb
    begin
        trial = (TW'(root_in) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        rem_w = TW'(rem_in);
        fits  = trial <= rem_w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= fits ? vmt_pkg::SUM_W'(rem_w - trial) : rem_in;
            root_out <= fits ? (root_in | (vmt_pkg::ROOT_W'(1) << BIT)) : root_in;
            pay_out  <= pay_in;
        end
    end
endmodule

/* rtl/core/vmt_div_stage.sv */
// One restoring divide step for a lane quotient: numerator bit in, quotient bit out.
// Depends on vmt_pkg.
module vmt_div_stage #(
    parameter int BIT = 0
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [vmt_pkg::ROOT_W-1:0] den,
    input  logic [vmt_pkg::PROD_W-1:0] num_in,
    input  logic [vmt_pkg::ROOT_W:0]   rem_in,
    input  logic [vmt_pkg::PROD_W-1:0] quo_in,
    output logic [vmt_pkg::ROOT_W:0]   rem_out,
    output logic [vmt_pkg::PROD_W-1:0] quo_out
);
    localparam int RW = vmt_pkg::ROOT_W + 1;
    logic [RW:0] sh;
    logic        ge;

    always_comb
    begin
        sh = {rem_in, num_in[BIT]};
        ge = sh >= (RW + 1)'(den);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= ge ? RW'(sh - (RW + 1)'(den)) : RW'(sh);
            quo_out <= quo_in | (ge ? (vmt_pkg::PROD_W'(1) << BIT) : '0);
        end
    end
endmodule

/* rtl/core/vmt_lane.sv */
// One axis lane: step product, then pipelined divide by the root.
// Depends on vmt_pkg and vmt_div_stage.
module vmt_lane (
    input  logic                        clk,
    input  logic                        en,
    input  vmt_pkg::lane_t              lane_in,
    input  logic [vmt_pkg::STEP_W-1:0]  step,
    input  logic [vmt_pkg::ROOT_W-1:0]  root,
    output vmt_pkg::lane_t              lane_out,
    output logic [vmt_pkg::PROD_W-1:0]  quo
);
    localparam int NS = vmt_pkg::PROD_W;

    logic [vmt_pkg::PROD_W-1:0] prod_reg;
    vmt_pkg::lane_t             l0_reg;
    logic [vmt_pkg::ROOT_W-1:0] den_reg;

    logic [vmt_pkg::ROOT_W:0]   rem  [NS+1];
    logic [vmt_pkg::PROD_W-1:0] qv   [NS+1];
    logic [vmt_pkg::PROD_W-1:0] num  [NS+1];
    logic [vmt_pkg::ROOT_W-1:0] den  [NS+1];
    vmt_pkg::lane_t             lp   [NS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= vmt_pkg::PROD_W'(lane_in.mag) * vmt_pkg::PROD_W'(step);
            l0_reg   <= lane_in;
            den_reg  <= root;
        end
    end

    assign rem[0] = '0;
    assign qv[0]  = '0;
    assign num[0] = prod_reg;
    assign den[0] = den_reg;
    assign lp[0]  = l0_reg;

    for (genvar s = 0; s < NS; s++)
    begin : g_div
        vmt_div_stage #(.BIT(NS - 1 - s)) u_stage (
            .clk(clk), .en(en), .den(den[s]), .num_in(num[s]),
            .rem_in(rem[s]), .quo_in(qv[s]), .rem_out(rem[s+1]), .quo_out(qv[s+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num[s+1] <= num[s];
                den[s+1] <= den[s];
                lp[s+1]  <= lp[s];
            end
        end
    end

    assign lane_out = lp[NS];
    assign quo      = qv[NS];
endmodule

/* rtl/core/vector_move_towards.sv */
// Top level of vector_move_towards: front end, root pipeline, lanes and merge.
// Depends on vmt_pkg, vmt_sqrt_stage, vmt_lane.
//
// Fully pipelined: one transaction accepted per clock while the pipe
// advances, through front end, square root (one bit per stage), step
// product, lane divide (one quotient bit per stage) and merge. The whole
// pipe advances when the output register is empty or being taken; while a
// result waits, every stage and the input stall with it. The three axis
// lanes run side by side and the merge stage picks move/hold/target.
module vector_move_towards #(
    parameter int EPSILON = vmt_pkg::EPSILON_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cx[31:0] cy[63:32] cz[95:64] tx[127:96] ty[159:128] tz[191:160] max_step[222:192]
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_x[31:0] new_y[63:32] new_z[95:64]
    output logic [95:0]  m_tdata,
    // reached[0]
    output logic         m_tuser
);
    localparam int W  = vmt_pkg::COORD_W;
    localparam int LAT = 2 + vmt_pkg::ROOT_W + 1 + vmt_pkg::PROD_W;
    localparam int PW = vmt_pkg::LANES * $bits(vmt_pkg::lane_t) + vmt_pkg::STEP_W + 1;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;

    // stage 1: differences and squares
    vmt_pkg::lane_t              ln1_reg [vmt_pkg::LANES];
    logic [vmt_pkg::SQ_W-1:0]    sq1_reg [vmt_pkg::LANES];
    logic [vmt_pkg::STEP_W-1:0]  st1_reg;

    for (genvar i = 0; i < vmt_pkg::LANES; i++)
    begin : g_front
        logic signed [W-1:0] c, t;
        logic signed [vmt_pkg::DIFF_W-1:0] d;
        logic [vmt_pkg::MAG_W-1:0] m;
        always_comb
        begin
            c = s_tdata[i*W +: W];
            t = s_tdata[(i+3)*W +: W];
            d = vmt_pkg::DIFF_W'(t) - vmt_pkg::DIFF_W'(c);
            m = vmt_pkg::MAG_W'(d[vmt_pkg::DIFF_W-1] ? -d : d);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ln1_reg[i] <= '{neg: d[vmt_pkg::DIFF_W-1], mag: m, cur: c, tgt: t};
                sq1_reg[i] <= vmt_pkg::SQ_W'(m) * vmt_pkg::SQ_W'(m);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st1_reg <= s_tdata[192 +: vmt_pkg::STEP_W];
    end

    // stage 2: sum of squares and reach test
    logic [vmt_pkg::SUM_W-1:0] sum2_reg;
    logic [PW-1:0]             pay2_reg;
    logic [vmt_pkg::SUM_W-1:0] sum_w;
    logic [vmt_pkg::SQ_W-1:0]  st2_w;

    always_comb
    begin
        sum_w = vmt_pkg::SUM_W'(sq1_reg[0]) + vmt_pkg::SUM_W'(sq1_reg[1])
              + vmt_pkg::SUM_W'(sq1_reg[2]);
        st2_w = vmt_pkg::SQ_W'(st1_reg) * vmt_pkg::SQ_W'(st1_reg);
    end

    // 31x31 square in the same cycle as the add; move flag = S > step^2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum2_reg <= sum_w;
            pay2_reg <= {sum_w > vmt_pkg::SUM_W'(st2_w), st1_reg,
                         ln1_reg[2], ln1_reg[1], ln1_reg[0]};
        end
    end

    // root pipeline
    logic [vmt_pkg::SUM_W-1:0]  srem [vmt_pkg::ROOT_W+1];
    logic [vmt_pkg::ROOT_W-1:0] sroot[vmt_pkg::ROOT_W+1];
    logic [PW-1:0]              spay [vmt_pkg::ROOT_W+1];
    assign srem[0]  = sum2_reg;
    assign sroot[0] = '0;
    assign spay[0]  = pay2_reg;

    for (genvar s = 0; s < vmt_pkg::ROOT_W; s++)
    begin : g_sqrt
        vmt_sqrt_stage #(.BIT(vmt_pkg::ROOT_W - 1 - s), .PW(PW)) u_sq (
            .clk(clk), .en(en), .rem_in(srem[s]), .root_in(sroot[s]),
            .pay_in(spay[s]), .rem_out(srem[s+1]), .root_out(sroot[s+1]),
            .pay_out(spay[s+1])
        );
    end

    localparam int LB = $bits(vmt_pkg::lane_t);
    logic [vmt_pkg::ROOT_W-1:0] root_f;
    logic [PW-1:0]              pay_f;
    logic [vmt_pkg::STEP_W-1:0] step_f;
    assign root_f = sroot[vmt_pkg::ROOT_W];
    assign pay_f  = spay[vmt_pkg::ROOT_W];
    assign step_f = pay_f[3*LB +: vmt_pkg::STEP_W];

    // control travels alongside the lanes
    logic [vmt_pkg::PROD_W:0] mv_pipe_reg;
    logic [vmt_pkg::PROD_W:0] hold_pipe_reg;
    logic mv_f, hold_f;
    assign mv_f   = pay_f[PW-1];
    assign hold_f = root_f <= vmt_pkg::ROOT_W'(EPSILON);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mv_pipe_reg   <= {mv_pipe_reg[vmt_pkg::PROD_W-1:0], mv_f};
            hold_pipe_reg <= {hold_pipe_reg[vmt_pkg::PROD_W-1:0], hold_f};
        end
    end

    vmt_pkg::lane_t             lo [vmt_pkg::LANES];
    logic [vmt_pkg::PROD_W-1:0] qo [vmt_pkg::LANES];

    for (genvar i = 0; i < vmt_pkg::LANES; i++)
    begin : g_lane
        vmt_lane u_lane (
            .clk(clk), .en(en), .lane_in(pay_f[i*LB +: LB]), .step(step_f),
            .root(hold_f ? vmt_pkg::ROOT_W'(1) : root_f), .lane_out(lo[i]), .quo(qo[i])
        );
    end

    // merge
    logic mv_m, hold_m;
    assign mv_m   = mv_pipe_reg[vmt_pkg::PROD_W];
    assign hold_m = hold_pipe_reg[vmt_pkg::PROD_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < vmt_pkg::LANES; i++)
            begin
                priority if (!mv_m)
                    m_tdata[i*W +: W] <= lo[i].tgt;
                else if (hold_m)
                    m_tdata[i*W +: W] <= lo[i].cur;
                else if (lo[i].neg)
                    m_tdata[i*W +: W] <= lo[i].cur - W'(qo[i]);
                else
                    m_tdata[i*W +: W] <= lo[i].cur + W'(qo[i]);
            end
            m_tuser <= !mv_m;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[LAT-2:0], s_tvalid};
            out_vld_reg <= vld_reg[LAT-1];
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[LAT-1] |=> m_tvalid)
        else $error("pipeline lost a transaction");
endmodule
